FILE: rtl/core/rc4_pkg.sv
`timescale 1ns / 1ps

package rc4_pkg;

	localparam int BYTE_W        = 8;
	localparam int BOX_DEPTH     = 256;
	localparam int BOX_AW        = $clog2(BOX_DEPTH);
	localparam int MAX_KEY_BYTES = 16;
	localparam int KEY_IDX_W     = $clog2(MAX_KEY_BYTES);
	localparam int KEY_W         = 64;
	localparam int LEN_W         = 5;
	localparam int CFG_IDX_W     = 2;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [BOX_AW-1:0] box_addr_t;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_LO  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HI  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN = 2'd2;

	localparam logic [LEN_W-1:0] KEY_LEN_RST = 5'd16;

	localparam logic OP_REKEY = 1'b0;
	localparam logic OP_CRYPT = 1'b1;

	localparam logic [1:0] RD_A   = 2'd0;
	localparam logic [1:0] RD_INC = 2'd1;
	localparam logic [1:0] RD_B   = 2'd2;
	localparam logic [1:0] RD_T   = 2'd3;

	localparam logic WR_A = 1'b0;
	localparam logic WR_B = 1'b1;

	typedef struct packed {
		logic       ld_item;
		logic       clr_box;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       ld_a_inc;
		logic       ld_ab;
		logic       key_add;
		logic       ld_t;
		logic       wr_en;
		logic       wr_sel;
		logic       crypt_done;
		logic       ks_step;
		logic       ks_done;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic k_last;
	} dp_sts_t;

endpackage

FILE: rtl/core/rc4_if.sv
`timescale 1ns / 1ps

interface rc4_in_if;
	logic           valid;
	logic           ready;
	logic           opcode;
	rc4_pkg::byte_t data_in;
	logic           in_last;

	modport source (output valid, output opcode, output data_in, output in_last, input ready);
	modport sink (input valid, input opcode, input data_in, input in_last, output ready);
endinterface

interface rc4_out_if;
	logic           valid;
	logic           ready;
	rc4_pkg::byte_t data_out;
	logic           out_last;

	modport source (output valid, output data_out, output out_last, input ready);
	modport sink (input valid, input data_out, input out_last, output ready);
endinterface

interface rc4_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [rc4_pkg::CFG_IDX_W-1:0]    index;
	logic [rc4_pkg::KEY_W-1:0]        data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/rc4_ram.sv
`timescale 1ns / 1ps

module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/core/rc4_ctrl.sv
`timescale 1ns / 1ps

module rc4_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_opcode,
	output logic             req_ready,
	input  rc4_pkg::dp_sts_t sts,
	output rc4_pkg::dp_cmd_t cmd
);
	import rc4_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_C_RDB = 3'd1;
	localparam logic [2:0] ST_C_WRA = 3'd2;
	localparam logic [2:0] ST_C_WRB = 3'd3;
	localparam logic [2:0] ST_K_RDA = 3'd4;
	localparam logic [2:0] ST_K_RDB = 3'd5;
	localparam logic [2:0] ST_K_WRA = 3'd6;
	localparam logic [2:0] ST_K_WRB = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		req_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.ld_item = 1'b1;
					if (req_opcode == OP_CRYPT) begin
						cmd.rd_en    = 1'b1;
						cmd.rd_sel   = RD_INC;
						cmd.ld_a_inc = 1'b1;
						state_d      = ST_C_RDB;
					end else begin
						cmd.clr_box = 1'b1;
						state_d     = ST_K_RDA;
					end
				end
			end
			ST_C_RDB: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_B;
				cmd.ld_ab  = 1'b1;
				state_d    = ST_C_WRA;
			end
			ST_C_WRA: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_A;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_T;
				cmd.ld_t   = 1'b1;
				state_d    = ST_C_WRB;
			end
			ST_C_WRB: begin
				// hold until the result register can take the byte
				if (sts.out_free) begin
					cmd.wr_en      = 1'b1;
					cmd.wr_sel     = WR_B;
					cmd.crypt_done = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_K_RDA: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_A;
				state_d    = ST_K_RDB;
			end
			ST_K_RDB: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = RD_B;
				cmd.ld_ab   = 1'b1;
				cmd.key_add = 1'b1;
				state_d     = ST_K_WRA;
			end
			ST_K_WRA: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_A;
				state_d    = ST_K_WRB;
			end
			ST_K_WRB: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_B;
				cmd.ks_step = 1'b1;
				if (sts.k_last) begin
					cmd.ks_done = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					state_d = ST_K_RDA;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/core/rc4_dp.sv
`timescale 1ns / 1ps

module rc4_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rc4_pkg::dp_cmd_t               cmd,
	output rc4_pkg::dp_sts_t               sts,
	input  rc4_pkg::byte_t                 req_data_in,
	input  logic                           req_in_last,
	input  logic                           cfg_valid,
	input  logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rc4_pkg::KEY_W-1:0]      cfg_data,
	input  logic                           rsp_ready,
	output logic                           rsp_valid,
	output rc4_pkg::byte_t                 rsp_data_out,
	output logic                           rsp_out_last
);
	import rc4_pkg::*;

	logic [KEY_W-1:0]     key_lo_q;
	logic [KEY_W-1:0]     key_hi_q;
	logic [LEN_W-1:0]     key_len_q;
	logic [LEN_W-1:0]     len_last;
	logic [2*KEY_W-1:0]   key_vec;
	byte_t                key_byte;
	byte_t                key_term;
	logic [KEY_IDX_W-1:0] kidx_q;

	box_addr_t            i_q;
	box_addr_t            j_q;
	box_addr_t            a_q;
	box_addr_t            b_q;
	box_addr_t            t_q;
	byte_t                va_q;
	byte_t                vb_q;
	logic [BOX_DEPTH-1:0] box_vld_q;

	box_addr_t            rd_addr;
	box_addr_t            rd_addr_q;
	logic                 rd_vld_q;
	byte_t                ram_rdata;
	byte_t                rd_val;
	box_addr_t            wr_addr;
	byte_t                wr_data;
	box_addr_t            b_n;
	box_addr_t            t_n;
	byte_t                ks;

	byte_t                data_q;
	logic                 last_q;
	logic                 out_valid_q;
	byte_t                data_out_q;
	logic                 out_last_q;

	// an entry never written since the last rekey holds its own index
	assign rd_val   = rd_vld_q ? ram_rdata : rd_addr_q;
	assign key_vec  = {key_hi_q, key_lo_q};
	assign key_byte = key_vec[{kidx_q, 3'b000} +: BYTE_W];
	assign key_term = cmd.key_add ? key_byte : '0;
	assign b_n      = j_q + rd_val + key_term;
	assign t_n      = va_q + rd_val;

	always_comb begin
		if (key_len_q == '0) begin
			len_last = '0;
		end else if (key_len_q > LEN_W'(MAX_KEY_BYTES)) begin
			len_last = LEN_W'(MAX_KEY_BYTES - 1);
		end else begin
			len_last = key_len_q - 1'b1;
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_A:    rd_addr = a_q;
			RD_INC:  rd_addr = i_q + 8'd1;
			RD_B:    rd_addr = b_n;
			RD_T:    rd_addr = t_n;
			default: rd_addr = a_q;
		endcase
	end

	assign wr_addr = (cmd.wr_sel == WR_B) ? b_q : a_q;
	assign wr_data = (cmd.wr_sel == WR_B) ? va_q : rd_val;

	// the read at t ran before the swap finished; patch it from the swapped values
	always_comb begin
		if (t_q == b_q) begin
			ks = va_q;
		end else if (t_q == a_q) begin
			ks = vb_q;
		end else begin
			ks = rd_val;
		end
	end

	rc4_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(BOX_DEPTH)
	) u_box (
		.clk    (clk),
		.wr_en  (cmd.wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_data(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q    <= '0;
			key_hi_q    <= '0;
			key_len_q   <= KEY_LEN_RST;
			i_q         <= '0;
			j_q         <= '0;
			box_vld_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_KEY_LO:  key_lo_q  <= cfg_data;
					REG_KEY_HI:  key_hi_q  <= cfg_data;
					REG_KEY_LEN: key_len_q <= cfg_data[LEN_W-1:0];
					default:     ;
				endcase
			end
			if (cmd.clr_box) begin
				box_vld_q <= '0;
			end else if (cmd.wr_en) begin
				box_vld_q[wr_addr] <= 1'b1;
			end
			if (cmd.clr_box || cmd.ks_done) begin
				i_q <= '0;
				j_q <= '0;
			end else if (cmd.crypt_done) begin
				i_q <= a_q;
				j_q <= b_q;
			end else if (cmd.ks_step) begin
				j_q <= b_q;
			end
			if (cmd.crypt_done) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_box) begin
			a_q    <= '0;
			kidx_q <= '0;
		end else if (cmd.ld_a_inc) begin
			a_q <= i_q + 8'd1;
		end else if (cmd.ks_step) begin
			a_q <= a_q + 8'd1;
			if (kidx_q == len_last[KEY_IDX_W-1:0]) begin
				kidx_q <= '0;
			end else begin
				kidx_q <= kidx_q + 1'b1;
			end
		end
		if (cmd.ld_ab) begin
			va_q <= rd_val;
			b_q  <= b_n;
		end
		if (cmd.ld_t) begin
			vb_q <= rd_val;
			t_q  <= t_n;
		end
		if (cmd.rd_en) begin
			rd_addr_q <= rd_addr;
			rd_vld_q  <= box_vld_q[rd_addr];
		end
		if (cmd.ld_item) begin
			data_q <= req_data_in;
			last_q <= req_in_last;
		end
		if (cmd.crypt_done) begin
			data_out_q <= data_q ^ ks;
			out_last_q <= last_q;
		end
	end

	assign sts.out_free = !out_valid_q || rsp_ready;
	assign sts.k_last   = (a_q == box_addr_t'(BOX_DEPTH - 1));

	assign rsp_valid    = out_valid_q;
	assign rsp_data_out = data_out_q;
	assign rsp_out_last = out_last_q;

endmodule

FILE: rtl/core/rc4_stream_cipher.sv
`timescale 1ns / 1ps

// Channel  Dir   Payload                      Transfer when
// req      in    opcode, data_in, in_last     req.valid && req.ready
// rsp      out   data_out, out_last           rsp.valid && rsp.ready
// cfg      in    index, data                  cfg.valid && cfg.ready
//
// Crypt byte: the dependent box reads at i, j and t plus the swap writes run through C_RDB,
// C_WRA and C_WRB; the result is registered in C_WRB; the next byte is taken in idle.
// Rekey: valid bits cleared at the transfer, then four RAM accesses per key-schedule swap.
// Reset: box reads as identity via per-entry valid bits, indices zero, key length 16.
// Stall: a result waits in the output register; the next crypt holds its last step
// while that register is full and not taken. cfg.ready is always high.

module rc4_stream_cipher (
	input logic clk,
	input logic arst_n,
	rc4_in_if.sink    req,
	rc4_out_if.source rsp,
	rc4_cfg_if.sink   cfg
);
	import rc4_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg.ready = 1'b1;

	rc4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_opcode(req.opcode),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rc4_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_data_in (req.data_in),
		.req_in_last (req.in_last),
		.cfg_valid   (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.rsp_ready   (rsp.ready),
		.rsp_valid   (rsp.valid),
		.rsp_data_out(rsp.data_out),
		.rsp_out_last(rsp.out_last)
	);

	a_no_box_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> !req.ready)
		else $error("box write while idle");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.crypt_done |-> (!rsp.valid || rsp.ready))
		else $error("pending result overwritten");

	a_rekey_on_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_box |-> (req.valid && req.ready && req.opcode == OP_REKEY))
		else $error("box cleared without rekey transfer");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.crypt_done |=> rsp.valid)
		else $error("crypt finished without result");

endmodule
